FILE: rtl/core/gfrm_pkg.sv
// Shared types and constants for the greedy face rectangle merge block.
package gfrm_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_TRIANGLE_CAP = 2'd2;

	localparam logic [6:0]  GRID_WIDTH_RST  = 7'd64;
	localparam logic [6:0]  GRID_HEIGHT_RST = 7'd64;
	localparam logic [15:0] TRI_CAP_RST     = 16'd3000;
	localparam logic [15:0] TRI_CAP_MIN     = 16'd12;
	localparam logic [16:0] TRI_PER_RECT    = 17'd2;

	typedef struct packed {
		logic        operation;
		logic [5:0]  row_index;
		logic [63:0] row_bits;
	} gfrm_req_t;

	typedef struct packed {
		logic [5:0]  rect_u;
		logic [5:0]  rect_v;
		logic [6:0]  rect_width;
		logic [6:0]  rect_height;
		logic [11:0] chunk_number;
		logic        done_res;
	} gfrm_rsp_t;

	typedef struct packed {
		logic we;
		logic re;
		logic clr;
	} gfrm_mem_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SCAN_PICK,
		ST_WID_IN,
		ST_WID_OUT,
		ST_SPAN,
		ST_CLR0,
		ST_HT_CHK,
		ST_FIN,
		ST_DONE
	} gfrm_state_t;

endpackage

FILE: rtl/core/gfrm_row_store.sv
// Row bitmap memory with per-row valid bits and registered read data.
module gfrm_row_store #(
	parameter int DEPTH = 64,
	parameter int W     = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gfrm_pkg::gfrm_mem_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [W-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [W-1:0]                 rdata
);
	import gfrm_pkg::*;

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [W-1:0]     rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ctl.re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	// rows never written since the last clear read as empty
	assign rdata = rvld_q ? rdata_q : '0;

	a_no_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.we && ctl.re |-> waddr != raddr)
		else $error("row store read and write hit the same row");

	a_no_clr_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |-> !ctl.we && !ctl.re)
		else $error("row store cleared during an access");

endmodule

FILE: rtl/core/gfrm_ffs.sv
// Two-level find-first-set: byte groups registered, group pick in the next cycle.
module gfrm_ffs #(
	parameter int W = 64
) (
	input  logic                  clk,
	input  logic [W-1:0]          vec,
	output logic                  found,
	output logic [$clog2(W)-1:0]  idx
);
	import gfrm_pkg::*;

	localparam int NG = (W + 7) / 8;
	localparam int IW = $clog2(W);

	logic [NG*8-1:0] pad;
	logic [NG-1:0]   grp_any;
	logic [2:0]      grp_idx [NG];
	logic [NG-1:0]   grp_any_s1;
	logic [2:0]      grp_idx_s1 [NG];

	assign pad = (NG*8)'(vec);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |pad[g*8 +: 8];
			grp_idx[g] = 3'd0;
			for (int b = 7; b >= 0; b--) begin
				if (pad[g*8 + b]) begin
					grp_idx[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any;
		for (int g = 0; g < NG; g++) begin
			grp_idx_s1[g] <= grp_idx[g];
		end
	end

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				found = 1'b1;
				idx   = IW'(g*8 + int'(grp_idx_s1[g]));
			end
		end
	end

endmodule

FILE: rtl/core/greedy_face_rectangle_merge.sv
// Greedy rectangle merge over a plane of exposed face cells: sequencer and top level.
// Load item: written to the row store in the cycle it is accepted; no result.
// Fetch item: rows are read from the scan position to a start cell, the run from it gives
//   the width, rows below are covered while they hold the span; done when no cell is left.
// One item is worked on at a time; the next is taken once the result is registered.
// Reset is asynchronous: row valid bits clear at once, so the store reads empty at once.
module greedy_face_rectangle_merge #(
	parameter int GRID_SIZE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  gfrm_pkg::gfrm_req_t req_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output gfrm_pkg::gfrm_rsp_t rsp_item,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import gfrm_pkg::*;

	localparam int W  = GRID_SIZE;
	localparam int AW = $clog2(GRID_SIZE);
	localparam int CW = $clog2(GRID_SIZE + 1);
	localparam logic [CW-1:0] GS_C = CW'(GRID_SIZE);

	function automatic logic [CW-1:0] clamp_grid(input logic [6:0] g);
		if (g == 7'd0) begin
			return CW'(1);
		end else if (int'(g) > GRID_SIZE) begin
			return GS_C;
		end
		return CW'(g);
	endfunction

	function automatic logic [W-1:0] low_mask(input logic [CW-1:0] n);
		logic [W-1:0] m;
		for (int i = 0; i < W; i++) begin
			m[i] = (i < int'(n));
		end
		return m;
	endfunction

	gfrm_state_t state_q, state_d;

	logic [6:0]    grid_width_q, grid_height_q;
	logic [15:0]   tri_cap_q;
	logic [CW-1:0] gw, gh;
	logic [W-1:0]  colmask, startmask;

	logic [AW-1:0] scan_row_q, scan_col_q;
	logic [CW-1:0] r_q;
	logic [W-1:0]  row_q, span_q;
	logic [AW-1:0] su_q, sv_q;
	logic [CW-1:0] w_q, h_q, ht_row_q, ht_row_nxt;
	logic [11:0]   chunk_q, chunk_nxt;
	logic [15:0]   tri_q, tri_nxt, cap_eff;
	logic [16:0]   tri_sum;
	logic          chunk_close;

	gfrm_rsp_t rsp_q;
	logic      rsp_valid_q;
	logic      slot_free;

	gfrm_mem_ctl_t mem_ctl;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [W-1:0]  mem_wdata, mem_rdata;
	logic          span_hit;

	logic [W-1:0]  ffs_vec;
	logic          ffs_found;
	logic [AW-1:0] ffs_idx;

	gfrm_row_store #(.DEPTH(GRID_SIZE), .W(W)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	gfrm_ffs #(.W(W)) u_ffs (
		.clk   (clk),
		.vec   (ffs_vec),
		.found (ffs_found),
		.idx   (ffs_idx)
	);

	assign gw         = clamp_grid(grid_width_q);
	assign gh         = clamp_grid(grid_height_q);
	assign colmask    = low_mask(gw);
	assign startmask  = (r_q == CW'(scan_row_q)) ? low_mask(CW'(scan_col_q)) : '0;
	assign ht_row_nxt = ht_row_q + CW'(1);
	assign span_hit   = (mem_rdata & span_q) == span_q;
	assign slot_free  = !rsp_valid_q || !rsp_stall;

	assign cap_eff     = (tri_cap_q < TRI_CAP_MIN) ? TRI_CAP_MIN : tri_cap_q;
	assign tri_sum     = {1'b0, tri_q} + TRI_PER_RECT;
	assign chunk_close = (tri_sum > {1'b0, cap_eff}) && (tri_q != 16'd0);
	assign chunk_nxt   = chunk_close ? chunk_q + 12'd1 : chunk_q;
	assign tri_nxt     = chunk_close ? TRI_PER_RECT[15:0] : tri_sum[15:0];

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_ctl   = '0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		ffs_vec   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_item.operation == OP_FETCH) begin
						state_d = ST_SCAN_RD;
					end else if (int'(req_item.row_index) < GRID_SIZE) begin
						mem_ctl.we = 1'b1;
						mem_waddr  = req_item.row_index[AW-1:0];
						mem_wdata  = req_item.row_bits[W-1:0];
					end
				end
			end
			ST_SCAN_RD: begin
				if (r_q >= gh) begin
					state_d = ST_DONE;
				end else begin
					mem_ctl.re = 1'b1;
					mem_raddr  = r_q[AW-1:0];
					state_d    = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				ffs_vec = mem_rdata & colmask & ~startmask;
				state_d = ST_SCAN_PICK;
			end
			ST_SCAN_PICK: begin
				state_d = ffs_found ? ST_WID_IN : ST_SCAN_RD;
			end
			ST_WID_IN: begin
				// a one in the inverted run marks the first missing cell
				ffs_vec = ~((row_q & colmask) >> su_q);
				state_d = ST_WID_OUT;
			end
			ST_WID_OUT: begin
				state_d = ST_SPAN;
			end
			ST_SPAN: begin
				state_d = ST_CLR0;
			end
			ST_CLR0: begin
				mem_ctl.we = 1'b1;
				mem_waddr  = sv_q;
				mem_wdata  = row_q & ~span_q;
				if (ht_row_q < gh) begin
					mem_ctl.re = 1'b1;
					mem_raddr  = ht_row_q[AW-1:0];
					state_d    = ST_HT_CHK;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_HT_CHK: begin
				if (span_hit) begin
					mem_ctl.we = 1'b1;
					mem_waddr  = ht_row_q[AW-1:0];
					mem_wdata  = mem_rdata & ~span_q;
					if (ht_row_nxt < gh) begin
						mem_ctl.re = 1'b1;
						mem_raddr  = ht_row_nxt[AW-1:0];
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					mem_ctl.clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			tri_cap_q     <= TRI_CAP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:   grid_width_q  <= cfg_data[6:0];
				CFG_GRID_HEIGHT:  grid_height_q <= cfg_data[6:0];
				CFG_TRIANGLE_CAP: tri_cap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			chunk_q     <= '0;
			tri_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN || state_q == ST_DONE) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_FIN && slot_free) begin
				chunk_q     <= chunk_nxt;
				tri_q       <= tri_nxt;
				scan_row_q  <= sv_q;
				scan_col_q  <= su_q;
			end
			if (state_q == ST_DONE && slot_free) begin
				scan_row_q  <= '0;
				scan_col_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				r_q <= CW'(scan_row_q);
			end
			ST_SCAN_CHK: begin
				row_q <= mem_rdata;
			end
			ST_SCAN_PICK: begin
				if (ffs_found) begin
					su_q <= ffs_idx;
					sv_q <= r_q[AW-1:0];
				end else begin
					r_q <= r_q + CW'(1);
				end
			end
			ST_WID_OUT: begin
				w_q <= ffs_found ? CW'(ffs_idx) : GS_C;
			end
			ST_SPAN: begin
				span_q   <= low_mask(w_q) << su_q;
				h_q      <= CW'(1);
				ht_row_q <= CW'(sv_q) + CW'(1);
			end
			ST_HT_CHK: begin
				if (span_hit) begin
					h_q      <= h_q + CW'(1);
					ht_row_q <= ht_row_nxt;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					rsp_q.rect_u       <= 6'(su_q);
					rsp_q.rect_v       <= 6'(sv_q);
					rsp_q.rect_width   <= 7'(w_q);
					rsp_q.rect_height  <= 7'(h_q);
					rsp_q.chunk_number <= chunk_nxt;
					rsp_q.done_res     <= 1'b0;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					rsp_q.rect_u       <= '0;
					rsp_q.rect_v       <= '0;
					rsp_q.rect_width   <= '0;
					rsp_q.rect_height  <= '0;
					rsp_q.chunk_number <= '0;
					rsp_q.done_res     <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN || state_q == ST_DONE))
		else $error("result raised outside finish or done");

	a_rect_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.done_res |-> rsp_q.rect_width != 7'd0 &&
			rsp_q.rect_height != 7'd0)
		else $error("rectangle with zero extent");

	a_height_track: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HT_CHK |-> ht_row_q == CW'(sv_q) + h_q && ht_row_q < gh)
		else $error("height row out of step");

	a_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_item.operation == OP_FETCH |=> state_q == ST_SCAN_RD)
		else $error("fetch did not start a scan");

endmodule

FILE: verif/tb_greedy_face_rectangle_merge.sv
// Testbench for greedy_face_rectangle_merge: random loads and fetches against a predictor.
module tb_greedy_face_rectangle_merge;
	import gfrm_pkg::*;

	localparam int ITEM_TARGET   = 1350;
	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int GRID          = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	gfrm_req_t   req_item = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	gfrm_rsp_t   rsp_item;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state and register copies
	logic [63:0] plane_rows [GRID];
	int          scan_u = 0;
	int          scan_v = 0;
	logic [11:0] chunk_idx = '0;
	logic [15:0] tri_total = '0;
	logic [6:0]  model_gw = GRID_WIDTH_RST;
	logic [6:0]  model_gh = GRID_HEIGHT_RST;
	logic [15:0] model_cap = TRI_CAP_RST;

	gfrm_req_t   item_feed [$];
	gfrm_rsp_t   rect_expect [$];
	gfrm_rsp_t   rect_want;
	int          items_sent = 0;
	int          planes_closed = 0;
	int          results_taken = 0;
	int          mismatches = 0;
	int          send_gap = 0;
	int          hold_left = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;

	greedy_face_rectangle_merge uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic logic [63:0] mask_low(input int n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic int clamp_size(input logic [6:0] g);
		if (g < 1) return 1;
		if (g > GRID) return GRID;
		return int'(g);
	endfunction

	task automatic merge_predict(input gfrm_req_t it);
		gfrm_rsp_t   rect;
		int          cols, rows, su, sv, w, h, cap;
		logic [63:0] bits, span;
		bit          found;
		rect = '0;
		if (it.operation == OP_LOAD) begin
			plane_rows[it.row_index] = it.row_bits;
		end else begin
			cols = clamp_size(model_gw);
			rows = clamp_size(model_gh);
			found = 1'b0;
			su = 0;
			sv = 0;
			for (int r = scan_v; r < rows && !found; r++) begin
				bits = plane_rows[r] & mask_low(cols);
				if (r == scan_v)
					bits &= ~mask_low(scan_u);
				if (bits != '0) begin
					su = 0;
					while (!bits[su]) su++;
					sv = r;
					found = 1'b1;
				end
			end
			if (!found) begin
				foreach (plane_rows[i]) plane_rows[i] = '0;
				scan_u = 0;
				scan_v = 0;
				rect.done_res = 1'b1;
				planes_closed++;
			end else begin
				w = 1;
				while (su + w < cols && plane_rows[sv][su + w]) w++;
				span = mask_low(w) << su;
				h = 1;
				while (sv + h < rows && (plane_rows[sv + h] & span) == span) h++;
				for (int d = 0; d < h; d++) plane_rows[sv + d] &= ~span;
				cap = (model_cap < TRI_CAP_MIN) ? int'(TRI_CAP_MIN) : int'(model_cap);
				if (int'(tri_total) + int'(TRI_PER_RECT) > cap && tri_total > 0) begin
					chunk_idx++;
					tri_total = '0;
				end
				tri_total += 16'(TRI_PER_RECT);
				scan_u = su;
				scan_v = sv;
				rect.rect_u = 6'(su);
				rect.rect_v = 6'(sv);
				rect.rect_width = 7'(w);
				rect.rect_height = 7'(h);
				rect.chunk_number = chunk_idx;
			end
			rect_expect.insert(rect_expect.size(), rect);
		end
	endtask

	task automatic log_mismatch(input string msg);
		$display("MISMATCH result %0d: %s", results_taken, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [11:0] got,
			input logic [11:0] want_v);
		if (got !== want_v)
			log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want_v));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_item <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && !req_stall) begin
				merge_predict(req_item);
				send_gap = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (!(req_valid && req_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (item_feed.size() > 0) begin
					req_item <= item_feed[0];
					item_feed.delete(0);
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rect_expect.size() == 0) begin
					log_mismatch("result with no fetch outstanding");
				end else begin
					rect_want = rect_expect[0];
					rect_expect.delete(0);
					compare_field("rect_u", rsp_item.rect_u, rect_want.rect_u);
					compare_field("rect_v", rsp_item.rect_v, rect_want.rect_v);
					compare_field("rect_width", rsp_item.rect_width, rect_want.rect_width);
					compare_field("rect_height", rsp_item.rect_height, rect_want.rect_height);
					compare_field("chunk_number", rsp_item.chunk_number,
						rect_want.chunk_number);
					compare_field("done_res", rsp_item.done_res, rect_want.done_res);
				end
				results_taken++;
				if (results_taken == 60 || results_taken == 500)
					hold_left = LONG_HOLD;
				else
					hold_left = no_idle ? 0 : $urandom_range(0, 3);
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_stall <= (hold_left > 0);
		end
	end

	task automatic push_item(input logic op, input logic [5:0] idx, input logic [63:0] bits);
		gfrm_req_t it;
		it.operation = op;
		it.row_index = idx;
		it.row_bits = bits;
		item_feed.insert(item_feed.size(), it);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_GRID_WIDTH: model_gw = val[6:0];
			CFG_GRID_HEIGHT: model_gh = val[6:0];
			CFG_TRIANGLE_CAP: model_cap = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (item_feed.size() != 0 || req_valid || rect_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [63:0] random_row(input logic [63:0] prev, input int cols);
		int lo, hi;
		lo = $urandom_range(0, cols - 1);
		hi = $urandom_range(lo, 63);
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			2: return mask_low(hi + 1) & ~mask_low(lo);
			3: return '1;
			default: return prev;
		endcase
	endfunction

	task automatic configure_phase(input int p);
		logic [15:0] gw, gh, cap;
		case (p)
			0: begin gw = 1; gh = 1; cap = 12; end
			1: begin gw = 0; gh = 0; cap = 0; end
			2: begin gw = 127; gh = 64; cap = 16'hFFFF; end
			3: begin gw = 8; gh = 8; cap = 13; end
			4: begin gw = 64; gh = 127; cap = 11; end
			5: begin gw = 5; gh = 3; cap = 12; end
			6: begin gw = 2; gh = 64; cap = 20; end
			default: begin
				gw = $urandom_range(1, 16);
				gh = $urandom_range(1, 16);
				cap = $urandom_range(12, 40);
			end
		endcase
		no_idle = (p % 3 == 2);
		write_reg(CFG_GRID_WIDTH, gw);
		write_reg(CFG_GRID_HEIGHT, gh);
		write_reg(CFG_TRIANGLE_CAP, cap);
	endtask

	// one plane: rows loaded mostly in runs, then mostly fetches, with an occasional load, until the done item
	task automatic run_plane();
		int          loads, closed_at, rows, cols, base;
		logic [63:0] prev;
		rows = clamp_size(model_gh);
		cols = clamp_size(model_gw);
		loads = $urandom_range(1, rows < 8 ? rows + 2 : 8);
		base = $urandom_range(0, rows - 1);
		prev = '0;
		for (int k = 0; k < loads; k++) begin
			prev = random_row(prev, cols);
			if ($urandom_range(0, 4) == 0)
				push_item(OP_LOAD, 6'($urandom), prev);
			else
				push_item(OP_LOAD, 6'((base + k) % rows), prev);
		end
		closed_at = planes_closed;
		while (planes_closed == closed_at) begin
			if ($urandom_range(0, 11) == 0)
				push_item(OP_LOAD, 6'($urandom), random_row(prev, cols));
			else
				push_item(OP_FETCH, 6'($urandom), {$urandom, $urandom});
			while (item_feed.size() >= 2) @(negedge clk);
		end
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int phase, budget;
		foreach (plane_rows[i]) plane_rows[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, full-width rows, corner cells, overwrite, load behind scan
		push_item(OP_FETCH, '0, '0);
		push_item(OP_LOAD, 6'd0, '1);
		push_item(OP_LOAD, 6'd1, '1);
		push_item(OP_LOAD, 6'd2, 64'hFFFF_FFFF_0000_0000);
		push_item(OP_LOAD, 6'd63, 64'h8000_0000_0000_0001);
		push_item(OP_LOAD, 6'd40, 64'h0000_0000_0000_00F0);
		push_item(OP_LOAD, 6'd40, '0);
		repeat (5) push_item(OP_FETCH, '1, '1);
		push_item(OP_LOAD, 6'd10, 64'h20);
		push_item(OP_LOAD, 6'd20, 64'h1);
		push_item(OP_FETCH, '0, '0);
		push_item(OP_LOAD, 6'd3, '1);
		push_item(OP_FETCH, '0, '0);
		push_item(OP_FETCH, '0, '0);
		wait_idle();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			configure_phase(phase);
			budget = items_sent + ((phase == 2 || phase == 4) ? 60 : 110);
			while (items_sent < budget) run_plane();
			wait_idle();
			phase++;
		end

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/gfrm_pkg.sv
rtl/core/gfrm_row_store.sv
rtl/core/gfrm_ffs.sv
rtl/core/greedy_face_rectangle_merge.sv
verif/tb_greedy_face_rectangle_merge.sv
